>>> src/sl_pkg.sv
// ----------------------------------------------------------------------------
// sl_pkg
// Types, token codes and character tables shared by the script lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package sl_pkg;

  typedef enum logic [5:0] {
    TK_END, TK_LP, TK_RP, TK_LC, TK_RC, TK_LB, TK_RB, TK_SEMI, TK_ADD_ASSIGN,
    TK_INC, TK_PLUS, TK_SUB_ASSIGN, TK_DEC, TK_MINUS, TK_MOD, TK_DIV_ASSIGN,
    TK_DIV, TK_POW, TK_MUL_ASSIGN, TK_MUL, TK_EQ, TK_ASSIGN, TK_LE, TK_LT, TK_GE,
    TK_GT, TK_NE, TK_NOT, TK_AND, TK_OR, TK_DOT, TK_COMMA, TK_COLON, TK_STRING,
    TK_NUMBER, TK_IDENT, TK_VAR, TK_CONST, TK_BOOL, TK_IF, TK_ELSE, TK_WHILE,
    TK_DO, TK_FUNCTION, TK_RETURN, TK_ERR_UNKNOWN, TK_ERR_NEWLINE, TK_ERR_END
  } tok_kind_e;

  typedef enum logic [3:0] {
    M_IDLE, M_OP, M_IDENT, M_INT, M_FRAC, M_EXP_SIGN, M_EXP, M_QUOTED,
    M_LINE, M_BLOCK, M_BLOCK_STAR, M_ERROR
  } lex_mode_e;

  typedef struct packed {
    tok_kind_e   kind;
    logic [15:0] off;
    logic [15:0] len;
    logic [15:0] col;
  } tok_t;

  localparam int unsigned KwMaxChars = 8;

  localparam logic [63:0] KwVar      = "var";
  localparam logic [63:0] KwConst    = "const";
  localparam logic [63:0] KwTrue     = "true";
  localparam logic [63:0] KwFalse    = "false";
  localparam logic [63:0] KwIf       = "if";
  localparam logic [63:0] KwElse     = "else";
  localparam logic [63:0] KwWhile    = "while";
  localparam logic [63:0] KwDo       = "do";
  localparam logic [63:0] KwFunction = "function";
  localparam logic [63:0] KwReturn   = "return";

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_op(logic [7:0] c);
    return c == "+" || c == "-" || c == "/" || c == "*" || c == "=" || c == "<" ||
           c == ">" || c == "!" || c == "&" || c == "|" || c == ".";
  endfunction

  function automatic tok_kind_e word_kind(logic [63:0] w, logic short_word);
    tok_kind_e k;
    k = TK_IDENT;
    if (short_word) begin
      if (w == KwVar) k = TK_VAR;
      else if (w == KwConst) k = TK_CONST;
      else if (w == KwTrue || w == KwFalse) k = TK_BOOL;
      else if (w == KwIf) k = TK_IF;
      else if (w == KwElse) k = TK_ELSE;
      else if (w == KwWhile) k = TK_WHILE;
      else if (w == KwDo) k = TK_DO;
      else if (w == KwFunction) k = TK_FUNCTION;
      else if (w == KwReturn) k = TK_RETURN;
    end
    return k;
  endfunction

  function automatic tok_kind_e single_kind(logic [7:0] h);
    tok_kind_e k;
    case (h)
      "+":     k = TK_PLUS;
      "-":     k = TK_MINUS;
      "/":     k = TK_DIV;
      "*":     k = TK_MUL;
      "=":     k = TK_ASSIGN;
      "<":     k = TK_LT;
      ">":     k = TK_GT;
      "!":     k = TK_NOT;
      ".":     k = TK_DOT;
      default: k = TK_ERR_UNKNOWN;
    endcase
    return k;
  endfunction

  // TK_END when the two bytes do not combine
  function automatic tok_kind_e pair_kind(logic [7:0] h, logic [7:0] b);
    tok_kind_e k;
    k = TK_END;
    if (b == "=") begin
      case (h)
        "+":     k = TK_ADD_ASSIGN;
        "-":     k = TK_SUB_ASSIGN;
        "/":     k = TK_DIV_ASSIGN;
        "*":     k = TK_MUL_ASSIGN;
        "=":     k = TK_EQ;
        "<":     k = TK_LE;
        ">":     k = TK_GE;
        "!":     k = TK_NE;
        default: k = TK_END;
      endcase
    end else if (h == b) begin
      case (h)
        "+":     k = TK_INC;
        "-":     k = TK_DEC;
        "*":     k = TK_POW;
        "&":     k = TK_AND;
        "|":     k = TK_OR;
        default: k = TK_END;
      endcase
    end
    return k;
  endfunction

  function automatic tok_kind_e punct_kind(logic [7:0] b);
    tok_kind_e k;
    case (b)
      "(":     k = TK_LP;
      ")":     k = TK_RP;
      "{":     k = TK_LC;
      "}":     k = TK_RC;
      "[":     k = TK_LB;
      "]":     k = TK_RB;
      ";":     k = TK_SEMI;
      "%":     k = TK_MOD;
      ",":     k = TK_COMMA;
      ":":     k = TK_COLON;
      default: k = TK_END;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

>>> src/sl_if.sv
// ----------------------------------------------------------------------------
// sl_if
// Valid/ready channels for text bytes in and tokens out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;
  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink (input valid, text_byte, end_of_text, output ready);
endinterface

interface sl_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [15:0] start_offset;
  logic [15:0] token_length;
  logic [15:0] start_column;
  logic        last_result;
  modport source (output valid, token_kind, start_offset, token_length, start_column,
                  last_result, input ready);
  modport sink (input valid, token_kind, start_offset, token_length, start_column,
                last_result, output ready);
endinterface

`default_nettype wire

>>> src/script_lexer_core.sv
// ----------------------------------------------------------------------------
// script_lexer_core
// Streaming tokenizer for a small script language, one text byte per beat.
//
// in_i carries one text byte per beat with a flag on the final byte; out_o
// carries tokens (kind, offset, length, column, last_result). Each byte is
// evaluated in the cycle it is accepted and its 0 to 3 tokens are loaded
// into a 3-entry result buffer; out_o shows the first token the next cycle.
// A byte that yields at most one token allows a new byte every cycle while
// the receiver keeps up; a byte that yields more holds the input while the
// buffer drains. When the receiver stalls, tokens wait in the buffer and
// input is taken again once the last buffered token is leaving. Reset clears
// the lexer to idle at offset and column zero and empties the buffer; the
// final byte also returns the lexer, not the buffer, to that idle state.
// ----------------------------------------------------------------------------
`default_nettype none

module script_lexer_core
  import sl_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 16
) (
  input  wire     clk_i,
  input  wire     rst_ni,
  sl_in_if.sink   in_i,
  sl_out_if.source out_o
);

  localparam int unsigned P = POSITION_BITS;
  localparam logic [P-1:0] PosMax = '1;

  lex_mode_e    mode_q, mode_d;
  logic [7:0]   hb_q, hb_d, qc_q, qc_d;
  logic [P-1:0] bi_q, bi_d, col_q, col_d, ts_q, ts_d, tsc_q, tsc_d, tl_q, tl_d;
  logic [63:0]  wb_q, wb_d;

  tok_t        slot [4];
  logic [3:0]  slot_v;
  tok_t        nbuf [3];
  logic [2:0]  nlast;
  logic [1:0]  ncnt;

  tok_t        buf_q [3];
  logic [2:0]  last_q;
  logic [1:0]  cnt_q;

  logic accept, pop;

  function automatic logic [P-1:0] sat_inc(logic [P-1:0] v);
    return (v == PosMax) ? v : v + 1'b1;
  endfunction

  function automatic tok_t mk(tok_kind_e k, logic [P-1:0] o, logic [P-1:0] l,
                              logic [P-1:0] c);
    tok_t t;
    t.kind = k;
    t.off  = 16'(o);
    t.len  = 16'(l);
    t.col  = 16'(c);
    return t;
  endfunction

  assign pop    = out_o.valid && out_o.ready;
  assign in_i.ready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_o.ready);
  assign accept = in_i.valid && in_i.ready;

  always_comb begin
    logic [7:0] b;
    logic       used;
    tok_kind_e  k;
    b      = in_i.text_byte;
    used   = 1'b1;
    k      = TK_END;
    mode_d = mode_q;
    hb_d   = hb_q;
    qc_d   = qc_q;
    bi_d   = bi_q;
    col_d  = col_q;
    ts_d   = ts_q;
    tsc_d  = tsc_q;
    tl_d   = tl_q;
    wb_d   = wb_q;
    slot_v = '0;
    for (int i = 0; i < 4; i++) slot[i] = mk(TK_END, '0, '0, '0);

    case (mode_q)
      M_OP: begin
        k = pair_kind(hb_q, b);
        if (k != TK_END) begin
          tl_d = P'(2);
          slot[0] = mk(k, ts_d, tl_d, tsc_d); slot_v[0] = 1'b1;
          mode_d = M_IDLE;
        end else if (hb_q == "/" && b == "/") begin
          mode_d = M_LINE;
        end else if (hb_q == "/" && b == "*") begin
          mode_d = M_BLOCK;
        end else if (hb_q == "." && is_digit(b)) begin
          tl_d = P'(2);
          mode_d = M_FRAC;
        end else begin
          k = single_kind(hb_q);
          slot[0] = mk(k, ts_d, tl_d, tsc_d); slot_v[0] = 1'b1;
          mode_d = (k == TK_ERR_UNKNOWN) ? M_ERROR : M_IDLE;
          used = (k == TK_ERR_UNKNOWN);
        end
      end
      M_IDENT: begin
        if (is_word(b)) begin
          if (tl_q < P'(KwMaxChars)) wb_d = {wb_q[55:0], b};
          tl_d = sat_inc(tl_q);
        end else begin
          slot[0] = mk(word_kind(wb_q, tl_q <= P'(KwMaxChars)), ts_q, tl_q, tsc_q);
          slot_v[0] = 1'b1;
          mode_d = M_IDLE;
          used = 1'b0;
        end
      end
      M_INT, M_FRAC, M_EXP_SIGN, M_EXP: begin
        if (is_digit(b)) begin
          if (mode_q == M_EXP_SIGN) mode_d = M_EXP;
        end else if (mode_q == M_INT && b == ".") begin
          mode_d = M_FRAC;
        end else if ((mode_q == M_INT || mode_q == M_FRAC) && (b == "e" || b == "E")) begin
          mode_d = M_EXP_SIGN;
        end else if (mode_q == M_EXP_SIGN && (b == "+" || b == "-")) begin
          mode_d = M_EXP;
        end else begin
          slot[0] = mk(TK_NUMBER, ts_q, tl_q, tsc_q); slot_v[0] = 1'b1;
          mode_d = M_IDLE;
          used = 1'b0;
        end
        if (used) tl_d = sat_inc(tl_q);
      end
      M_QUOTED: begin
        if (b == qc_q) begin
          slot[0] = mk(TK_STRING, ts_q, tl_q, tsc_q); slot_v[0] = 1'b1;
          mode_d = M_IDLE;
        end else if (b == 8'd10 || b == 8'd13) begin
          slot[0] = mk(TK_ERR_NEWLINE, bi_q, P'(1), col_q); slot_v[0] = 1'b1;
          mode_d = M_ERROR;
        end else begin
          tl_d = sat_inc(tl_q);
        end
      end
      M_LINE: begin
        if (b == 8'd10) mode_d = M_IDLE;
      end
      M_BLOCK: begin
        if (b == "*") mode_d = M_BLOCK_STAR;
      end
      M_BLOCK_STAR: begin
        if (b == "/") mode_d = M_IDLE;
        else if (b != "*") mode_d = M_BLOCK;
      end
      M_ERROR: begin
      end
      default: begin
        used = 1'b0;
        mode_d = M_IDLE;
      end
    endcase

    if (!used) begin
      k = punct_kind(b);
      if (k != TK_END) begin
        slot[1] = mk(k, bi_q, P'(1), col_q); slot_v[1] = 1'b1;
      end else if (is_op(b)) begin
        ts_d = bi_q; tsc_d = col_q; tl_d = P'(1);
        hb_d = b;
        mode_d = M_OP;
      end else if (b == 8'h27 || b == 8'h22) begin
        ts_d = sat_inc(bi_q); tsc_d = col_q; tl_d = '0;
        qc_d = b;
        mode_d = M_QUOTED;
      end else if (is_digit(b)) begin
        ts_d = bi_q; tsc_d = col_q; tl_d = P'(1);
        mode_d = M_INT;
      end else if (is_space(b)) begin
      end else if (is_word(b)) begin
        ts_d = bi_q; tsc_d = col_q; tl_d = P'(1);
        wb_d = {56'd0, b};
        mode_d = M_IDENT;
      end else begin
        slot[1] = mk(TK_ERR_UNKNOWN, bi_q, P'(1), col_q); slot_v[1] = 1'b1;
        mode_d = M_ERROR;
      end
    end

    bi_d  = sat_inc(bi_q);
    col_d = (b == 8'd10) ? '0 : sat_inc(col_q);

    if (in_i.end_of_text) begin
      case (mode_d)
        M_QUOTED: begin
          slot[2] = mk(TK_ERR_END, ts_d, tl_d, tsc_d); slot_v[2] = 1'b1;
        end
        M_OP: begin
          slot[2] = mk(single_kind(hb_d), ts_d, tl_d, tsc_d); slot_v[2] = 1'b1;
        end
        M_IDENT: begin
          slot[2] = mk(word_kind(wb_d, tl_d <= P'(KwMaxChars)), ts_d, tl_d, tsc_d);
          slot_v[2] = 1'b1;
        end
        M_INT, M_FRAC, M_EXP_SIGN, M_EXP: begin
          slot[2] = mk(TK_NUMBER, ts_d, tl_d, tsc_d); slot_v[2] = 1'b1;
        end
        default: begin
        end
      endcase
      slot[3] = mk(TK_END, bi_d, '0, col_d); slot_v[3] = 1'b1;
      mode_d = M_IDLE;
      hb_d = '0; qc_d = '0; bi_d = '0; col_d = '0;
      ts_d = '0; tsc_d = '0; tl_d = '0; wb_d = '0;
    end
  end

  // pack the valid slots in order, keep at most three
  always_comb begin
    logic [2:0] n;
    n = '0;
    nlast = '0;
    for (int i = 0; i < 3; i++) nbuf[i] = slot[3];
    for (int i = 0; i < 4; i++) begin
      if (slot_v[i] && n < 3'd3) begin
        nbuf[n[1:0]] = slot[i];
        n = n + 3'd1;
      end
    end
    ncnt = n[1:0];
    if (n != 3'd0) nlast[n[1:0] - 2'd1] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      hb_q   <= '0;
      qc_q   <= '0;
      bi_q   <= '0;
      col_q  <= '0;
      ts_q   <= '0;
      tsc_q  <= '0;
      tl_q   <= '0;
      wb_q   <= '0;
      cnt_q  <= '0;
    end else begin
      if (accept) begin
        mode_q <= mode_d;
        hb_q   <= hb_d;
        qc_q   <= qc_d;
        bi_q   <= bi_d;
        col_q  <= col_d;
        ts_q   <= ts_d;
        tsc_q  <= tsc_d;
        tl_q   <= tl_d;
        wb_q   <= wb_d;
        cnt_q  <= ncnt;
      end else if (pop) begin
        cnt_q  <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      buf_q  <= nbuf;
      last_q <= nlast;
    end else if (pop) begin
      buf_q[0]  <= buf_q[1];
      buf_q[1]  <= buf_q[2];
      last_q    <= {1'b0, last_q[2:1]};
    end
  end

  assign out_o.valid        = cnt_q != 2'd0;
  assign out_o.token_kind   = buf_q[0].kind;
  assign out_o.start_offset = buf_q[0].off;
  assign out_o.token_length = buf_q[0].len;
  assign out_o.start_column = buf_q[0].col;
  assign out_o.last_result  = last_q[0];

endmodule

`default_nettype wire

>>> tb/script_lexer_core_checker.sv
// ----------------------------------------------------------------------------
// script_lexer_core_checker
// Watches the byte and token channels of the script lexer, predicts the token
// stream from every accepted byte and compares each token beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module script_lexer_core_checker
  import sl_pkg::*;
(
  input  wire     clk_i,
  input  wire     rst_ni,
  sl_in_if        in_i,
  sl_out_if       out_i,
  output int      fail_count_o,
  output int      pending_o,
  output int      bytes_seen_o,
  output int      tokens_seen_o
);

  typedef struct {
    tok_t t;
    logic last;
  } lex_tok_t;

  lex_tok_t   tok_q[$];
  lex_mode_e  mode;
  logic [7:0] held, quote;
  logic [15:0] pos, col, tstart, tcol, tlen;
  logic [63:0] word;
  int         n_step;

  assign pending_o = tok_q.size();

  function automatic logic [15:0] sat1(logic [15:0] v);
    return (v == 16'hffff) ? v : v + 16'd1;
  endfunction

  function automatic logic digit_c(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic word_c(logic [7:0] c);
    return digit_c(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  task automatic push_tok(tok_kind_e k, logic [15:0] o, logic [15:0] l, logic [15:0] c);
    lex_tok_t e;
    e.t.kind = k;
    e.t.off = o;
    e.t.len = l;
    e.t.col = c;
    e.last = 1'b0;
    tok_q = {tok_q, e};
    n_step++;
  endtask

  task automatic clear_lexer();
    mode = M_IDLE;
    held = '0;
    quote = '0;
    pos = '0;
    col = '0;
    tstart = '0;
    tcol = '0;
    tlen = '0;
    word = '0;
  endtask

  function automatic tok_kind_e kw_lookup();
    if (tlen > KwMaxChars) return TK_IDENT;
    if (word == KwVar) return TK_VAR;
    if (word == KwConst) return TK_CONST;
    if (word == KwTrue || word == KwFalse) return TK_BOOL;
    if (word == KwIf) return TK_IF;
    if (word == KwElse) return TK_ELSE;
    if (word == KwWhile) return TK_WHILE;
    if (word == KwDo) return TK_DO;
    if (word == KwFunction) return TK_FUNCTION;
    if (word == KwReturn) return TK_RETURN;
    return TK_IDENT;
  endfunction

  function automatic tok_kind_e lone_op(logic [7:0] h);
    case (h)
      "+": return TK_PLUS;
      "-": return TK_MINUS;
      "/": return TK_DIV;
      "*": return TK_MUL;
      "=": return TK_ASSIGN;
      "<": return TK_LT;
      ">": return TK_GT;
      "!": return TK_NOT;
      ".": return TK_DOT;
      default: return TK_ERR_UNKNOWN;
    endcase
  endfunction

  function automatic tok_kind_e joined_op(logic [7:0] h, logic [7:0] b);
    if (b == "=") begin
      case (h)
        "+": return TK_ADD_ASSIGN;
        "-": return TK_SUB_ASSIGN;
        "/": return TK_DIV_ASSIGN;
        "*": return TK_MUL_ASSIGN;
        "=": return TK_EQ;
        "<": return TK_LE;
        ">": return TK_GE;
        "!": return TK_NE;
        default: return TK_END;
      endcase
    end
    if (h == b) begin
      case (h)
        "+": return TK_INC;
        "-": return TK_DEC;
        "*": return TK_POW;
        "&": return TK_AND;
        "|": return TK_OR;
        default: return TK_END;
      endcase
    end
    return TK_END;
  endfunction

  task automatic finish_held();
    tok_kind_e k;
    case (mode)
      M_OP: begin
        k = lone_op(held);
        push_tok(k, tstart, tlen, tcol);
        mode = (k == TK_ERR_UNKNOWN) ? M_ERROR : M_IDLE;
      end
      M_IDENT: begin
        push_tok(kw_lookup(), tstart, tlen, tcol);
        mode = M_IDLE;
      end
      M_INT, M_FRAC, M_EXP_SIGN, M_EXP: begin
        push_tok(TK_NUMBER, tstart, tlen, tcol);
        mode = M_IDLE;
      end
      default: ;
    endcase
  endtask

  task automatic open_token(logic [7:0] b);
    tok_kind_e k;
    case (b)
      "(": k = TK_LP;
      ")": k = TK_RP;
      "{": k = TK_LC;
      "}": k = TK_RC;
      "[": k = TK_LB;
      "]": k = TK_RB;
      ";": k = TK_SEMI;
      "%": k = TK_MOD;
      ",": k = TK_COMMA;
      ":": k = TK_COLON;
      default: k = TK_END;
    endcase
    if (k != TK_END) begin
      push_tok(k, pos, 16'd1, col);
    end else if (b == "+" || b == "-" || b == "/" || b == "*" || b == "=" || b == "<" ||
                 b == ">" || b == "!" || b == "&" || b == "|" || b == ".") begin
      tstart = pos; tcol = col; tlen = 16'd1;
      held = b;
      mode = M_OP;
    end else if (b == "'" || b == "\"") begin
      tstart = sat1(pos); tcol = col; tlen = 16'd0;
      quote = b;
      mode = M_QUOTED;
    end else if (digit_c(b)) begin
      tstart = pos; tcol = col; tlen = 16'd1;
      mode = M_INT;
    end else if (b == " " || (b >= 8'd9 && b <= 8'd13)) begin
    end else if (word_c(b)) begin
      tstart = pos; tcol = col; tlen = 16'd1;
      word = {56'd0, b};
      mode = M_IDENT;
    end else begin
      push_tok(TK_ERR_UNKNOWN, pos, 16'd1, col);
      mode = M_ERROR;
    end
  endtask

  task automatic lex_byte(logic [7:0] b, logic eot);
    logic      taken;
    tok_kind_e k;
    taken = 1'b1;
    n_step = 0;
    case (mode)
      M_OP: begin
        k = joined_op(held, b);
        if (k != TK_END) begin
          tlen = 16'd2;
          push_tok(k, tstart, tlen, tcol);
          mode = M_IDLE;
        end else if (held == "/" && b == "/") begin
          mode = M_LINE;
        end else if (held == "/" && b == "*") begin
          mode = M_BLOCK;
        end else if (held == "." && digit_c(b)) begin
          tlen = 16'd2;
          mode = M_FRAC;
        end else begin
          finish_held();
          taken = (mode == M_ERROR);
        end
      end
      M_IDENT: begin
        if (word_c(b)) begin
          if (tlen < KwMaxChars) word = {word[55:0], b};
          tlen = sat1(tlen);
        end else begin
          finish_held();
          taken = 1'b0;
        end
      end
      M_INT, M_FRAC, M_EXP_SIGN, M_EXP: begin
        if (digit_c(b)) begin
          if (mode == M_EXP_SIGN) mode = M_EXP;
        end else if (mode == M_INT && b == ".") begin
          mode = M_FRAC;
        end else if ((mode == M_INT || mode == M_FRAC) && (b == "e" || b == "E")) begin
          mode = M_EXP_SIGN;
        end else if (mode == M_EXP_SIGN && (b == "+" || b == "-")) begin
          mode = M_EXP;
        end else begin
          finish_held();
          taken = 1'b0;
        end
        if (taken) tlen = sat1(tlen);
      end
      M_QUOTED: begin
        if (b == quote) begin
          push_tok(TK_STRING, tstart, tlen, tcol);
          mode = M_IDLE;
        end else if (b == 8'd10 || b == 8'd13) begin
          push_tok(TK_ERR_NEWLINE, pos, 16'd1, col);
          mode = M_ERROR;
        end else begin
          tlen = sat1(tlen);
        end
      end
      M_LINE: if (b == 8'd10) mode = M_IDLE;
      M_BLOCK: if (b == "*") mode = M_BLOCK_STAR;
      M_BLOCK_STAR: begin
        if (b == "/") mode = M_IDLE;
        else if (b != "*") mode = M_BLOCK;
      end
      M_ERROR: ;
      default: begin
        taken = 1'b0;
        mode = M_IDLE;
      end
    endcase
    if (!taken) open_token(b);
    pos = sat1(pos);
    col = (b == 8'd10) ? 16'd0 : sat1(col);
    if (eot) begin
      if (mode == M_QUOTED) push_tok(TK_ERR_END, tstart, tlen, tcol);
      else finish_held();
      push_tok(TK_END, pos, 16'd0, col);
      clear_lexer();
    end
    if (n_step > 0) tok_q[tok_q.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lex_tok_t e;
    if (!rst_ni) begin
      clear_lexer();
      tok_q.delete();
      fail_count_o <= 0;
      bytes_seen_o <= 0;
      tokens_seen_o <= 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        tokens_seen_o <= tokens_seen_o + 1;
        if (tok_q.size() == 0) begin
          $error("unexpected token beat kind %0d", out_i.token_kind);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = tok_q.pop_front();
          if (out_i.token_kind !== e.t.kind ||
              out_i.start_offset !== e.t.off || out_i.token_length !== e.t.len ||
              out_i.start_column !== e.t.col || out_i.last_result !== e.last)
            fail_count_o <= fail_count_o + 1;
          if (out_i.token_kind !== e.t.kind)
            $error("token_kind expected %0d actual %0d", e.t.kind, out_i.token_kind);
          if (out_i.start_offset !== e.t.off)
            $error("start_offset expected %0d actual %0d", e.t.off, out_i.start_offset);
          if (out_i.token_length !== e.t.len)
            $error("token_length expected %0d actual %0d", e.t.len, out_i.token_length);
          if (out_i.start_column !== e.t.col)
            $error("start_column expected %0d actual %0d", e.t.col, out_i.start_column);
          if (out_i.last_result !== e.last)
            $error("last_result expected %0d actual %0d", e.last, out_i.last_result);
        end
      end
      if (in_i.valid && in_i.ready) begin
        bytes_seen_o <= bytes_seen_o + 1;
        lex_byte(in_i.text_byte, in_i.end_of_text);
      end
    end
  end

endmodule

`default_nettype wire

>>> tb/script_lexer_core_tb.sv
// ----------------------------------------------------------------------------
// script_lexer_core_tb
// Feeds short scripts to the lexer: directed scripts for many token kinds,
// each keyword, number forms, comments and errors, then random scripts built
// from token fragments with noise bytes and cut-off endings. Both channels
// stall at random; a separate checker predicts and compares every token.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module script_lexer_core_tb;

  localparam int StallLimit = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   idle_pct = 10;
  int   fail_count, pending, bytes_seen, tokens_seen;
  int   quiet_cycles = 0;
  int   sent = 0;

  sl_in_if  in_ch ();
  sl_out_if out_ch ();

  always #10 clk_i = ~clk_i;

  script_lexer_core DUT (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch));

  script_lexer_core_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_i(out_ch),
    .fail_count_o(fail_count), .pending_o(pending),
    .bytes_seen_o(bytes_seen), .tokens_seen_o(tokens_seen)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.text_byte = '0;
    in_ch.end_of_text = 1'b0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk_i) out_ch.ready <= ($urandom_range(99) >= idle_pct);

  // watchdog: no beat on either side for too long
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("script_lexer_core_tb failed");
      $finish;
    end
  end

  string frags[] = '{"var", "const", "true", "false", "if", "else", "while", "do",
    "function", "return", "functions", "x_1", "abcdefghij", "Ab9", "doX", "12", "3.5",
    "1.", "1e5", "2E+7", "3e-", "4e", ".5", ".", "..", "7.2.3", "+", "++", "+=", "-",
    "--", "-=", "*", "**", "*=", "/", "/=", "<", "<=", ">", ">=", "=", "==", "!", "!=",
    "&&", "||", "(", ")", "{", "}", "[", "]", ";", "%", ",", ":", "'ab'", "\"c d\"",
    "'x\"y'", "''", "// c\n", "/* a ** b */", "/**/", " ", "\t", "\n", "\r"};

  task automatic send_byte(logic [7:0] b, logic eot);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.text_byte <= b;
    in_ch.end_of_text <= eot;
    do @(posedge clk_i); while (!in_ch.ready);
    sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic send_random_script();
    string s;
    int    nf;
    s = "";
    nf = $urandom_range(12, 1);
    for (int i = 0; i < nf; i++) begin
      if ($urandom_range(99) < 6) s = {s, string'(8'($urandom_range(255, 1)))};
      else s = {s, frags[$urandom_range(frags.size() - 1)]};
      if ($urandom_range(1)) s = {s, " "};
    end
    case ($urandom_range(9))
      0: s = {s, "'open"};
      1: s = {s, "/* open"};
      2: s = {s, "// open"};
      default: ;
    endcase
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
    if ($urandom_range(19) == 0) send_byte(8'h00, $urandom_range(1));
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_text("var x=1.5e+3;\nif(a<=b)do{c+=d--}else return;");
    send_text("while function const true false ++ -- ** == != >= -= *= /= % , : [ ] .5 ..");
    send_text("'abc\n' x");
    send_text("\"abc");
    send_text("a&b");
    send_text("a|b /* x */ // y\nq");
    send_text("/* open *");
    send_byte(8'hff, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'h00, 1'b1);
    send_text("z");
    // sender holds off until all tokens so far have drained
    in_ch.valid <= 1'b0;
    wait (pending == 0);
    @(posedge clk_i);
    while (sent < 180) send_random_script();
    idle_pct = 0;
    while (sent < 230) send_random_script();
    idle_pct = 10;
    while (sent < 260) send_random_script();
    in_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (10) @(posedge clk_i);
    $display("covered %0d text bytes and %0d tokens, all kinds and error paths,", bytes_seen,
             tokens_seen);
    $display("with random stalls on both channels and a stall-free stretch");
    if (fail_count == 0 && pending == 0) begin
      $display("script_lexer_core_tb passed");
    end else begin
      $display("script_lexer_core_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
